// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// short forms for clocked concurrent assertions with an active-low reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

// condition never holds
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed: forbidden condition");

`endif

// ----- hw/rtl/tlpc_pkg.sv -----
// ----------------------------------------------------------------------------
// tlpc_pkg
// shared types, opcodes and sizes of the tilelink protocol checker
// ----------------------------------------------------------------------------
`default_nettype none

package tlpc_pkg;

	// fixed field widths of one sampled word
	localparam int OpcodeW = 3;
	localparam int ParamW  = 3;
	localparam int SizeW   = 4;
	localparam int SourceW = 4;
	localparam int AddrW   = 32;
	localparam int MaskW   = 8;
	localparam int SinkW   = 4;

	// widest lane vector the alignment window can reach
	localparam int LaneW = 64;

	// burst control snapshots
	localparam int ACtlW = OpcodeW + ParamW + SizeW + SourceW + AddrW;
	localparam int DCtlW = OpcodeW + ParamW + SizeW + SourceW + SinkW + 1;

	// parameter defaults
	localparam int DefBeatBytes  = 8;
	localparam int DefSourceBits = 4;

	// channel select
	localparam logic ChanA = 1'b0;
	localparam logic ChanD = 1'b1;

	// a channel opcodes
	localparam logic [OpcodeW-1:0] OpPutFull    = 3'd0;
	localparam logic [OpcodeW-1:0] OpPutPartial = 3'd1;
	localparam logic [OpcodeW-1:0] OpArithmetic = 3'd2;
	localparam logic [OpcodeW-1:0] OpLogical    = 3'd3;
	localparam logic [OpcodeW-1:0] OpGet        = 3'd4;
	localparam logic [OpcodeW-1:0] OpIntent     = 3'd5;

	// d channel opcodes
	localparam logic [OpcodeW-1:0] OpAccessAck     = 3'd0;
	localparam logic [OpcodeW-1:0] OpAccessAckData = 3'd1;
	localparam logic [OpcodeW-1:0] OpHintAck       = 3'd2;
	localparam logic [OpcodeW-1:0] OpGrantData     = 3'd5;

	typedef struct packed {
		logic               op;
		logic               valid_req;
		logic               ready_req;
		logic [OpcodeW-1:0] opcode;
		logic [ParamW-1:0]  param;
		logic [SizeW-1:0]   size;
		logic [SourceW-1:0] source;
		logic [AddrW-1:0]   address;
		logic [MaskW-1:0]   mask;
		logic [SinkW-1:0]   sink;
		logic               error;
	} sample_t;

	typedef struct packed {
		logic size_mismatch;
		logic wrong_response;
		logic misaligned;
		logic mask_extra_lane;
		logic mask_missing_lane;
		logic burst_unstable;
	} result_t;

	// per-source request record
	typedef struct packed {
		logic [OpcodeW-1:0] opc;
		logic [SizeW-1:0]   sz;
	} rec_t;

	localparam rec_t RecReset = '{opc: OpIntent, sz: '0};

	// write port of the request table
	typedef struct packed {
		logic               en;
		logic [SourceW-1:0] source;
		rec_t               data;
	} rec_wr_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tlpc_record.sv -----
// ----------------------------------------------------------------------------
// tlpc_record
// request record table: opcode and size per source, read into stage one
// ----------------------------------------------------------------------------
`default_nettype none

module tlpc_record #(
	parameter int SOURCE_BITS = tlpc_pkg::DefSourceBits
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              rd_en,
	input  wire logic [tlpc_pkg::SourceW-1:0]      rd_source,
	input  wire tlpc_pkg::rec_wr_t                 wr,
	output tlpc_pkg::rec_t                         rec
);

	localparam int Depth = 1 << SOURCE_BITS;
	localparam int ExtW  = (SOURCE_BITS > tlpc_pkg::SourceW) ? SOURCE_BITS : tlpc_pkg::SourceW;

	tlpc_pkg::rec_t mem [Depth];
	logic [Depth-1:0] vld_q;

	logic [ExtW-1:0]        rd_ext, wr_ext;
	logic [SOURCE_BITS-1:0] rd_idx, wr_idx;
	logic                   hit;

	tlpc_pkg::rec_t mem_rd_s1;
	tlpc_pkg::rec_t fwd_s1;
	logic           hit_s1;
	logic           vld_s1;

	// source is zero-extended or cut to the table index width
	assign rd_ext = ExtW'(rd_source);
	assign wr_ext = ExtW'(wr.source);
	assign rd_idx = rd_ext[SOURCE_BITS-1:0];
	assign wr_idx = wr_ext[SOURCE_BITS-1:0];
	assign hit    = wr.en && (wr_idx == rd_idx);

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr_idx] <= wr.data;
		end
		if (rd_en) begin
			mem_rd_s1 <= mem[rd_idx];
			fwd_s1    <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			hit_s1 <= 1'b0;
			vld_s1 <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				// a write in the same edge would be missed by the array read
				hit_s1 <= hit;
				vld_s1 <= vld_q[rd_idx];
			end
		end
	end

	assign rec = hit_s1 ? fwd_s1 : (vld_s1 ? mem_rd_s1 : tlpc_pkg::RecReset);

endmodule

`default_nettype wire

// ----- hw/rtl/tlpc_burst.sv -----
// ----------------------------------------------------------------------------
// tlpc_burst
// multi-beat burst tracker: captures the first beat and compares later beats
// ----------------------------------------------------------------------------
`default_nettype none

module tlpc_burst #(
	parameter int BEAT_BYTES = tlpc_pkg::DefBeatBytes,
	parameter int CTL_BITS   = tlpc_pkg::DCtlW,
	parameter int CMP_BITS   = tlpc_pkg::DCtlW
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step,
	input  wire logic                        start_ok,
	input  wire logic [tlpc_pkg::SizeW-1:0]  size,
	input  wire logic [CTL_BITS-1:0]         ctl,
	output logic                             unstable
);

	localparam int LogBb   = $clog2(BEAT_BYTES);
	localparam int MaxSize = (1 << tlpc_pkg::SizeW) - 1;
	localparam int BeatW   = MaxSize - LogBb + 1;
	localparam logic [CTL_BITS-1:0] EveryBeat = {CTL_BITS{1'b1}} >> (CTL_BITS - CMP_BITS);

	logic                active_q;
	logic [BeatW-1:0]    left_q;
	logic [CTL_BITS-1:0] cap_q;

	logic                last_beat;
	logic                multi;
	logic [BeatW-1:0]    beats_m1;
	logic [CTL_BITS-1:0] cmp_mask;

	assign last_beat = (left_q == BeatW'(1));
	assign multi     = (size > tlpc_pkg::SizeW'(LogBb));
	assign beats_m1  = (BeatW'(1) << (size - tlpc_pkg::SizeW'(LogBb))) - BeatW'(1);
	// fields above the compared range count on the last beat only
	assign cmp_mask  = last_beat ? {CTL_BITS{1'b1}} : EveryBeat;
	assign unstable  = step && active_q && (((ctl ^ cap_q) & cmp_mask) != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			left_q   <= '0;
		end else if (step) begin
			if (active_q) begin
				left_q <= left_q - BeatW'(1);
				if (last_beat) begin
					active_q <= 1'b0;
				end
			end else if (start_ok && multi) begin
				active_q <= 1'b1;
				left_q   <= beats_m1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && !active_q && start_ok && multi) begin
			cap_q <= ctl;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/tlpc_check.sv -----
// ----------------------------------------------------------------------------
// tlpc_check
// per-word checks: response against record, alignment and byte lanes
// ----------------------------------------------------------------------------
`default_nettype none

module tlpc_check #(
	parameter int BEAT_BYTES = tlpc_pkg::DefBeatBytes
) (
	input  wire tlpc_pkg::sample_t smp,
	input  wire tlpc_pkg::rec_t    rec,
	input  wire logic              a_unstable,
	input  wire logic              d_unstable,
	output tlpc_pkg::result_t      res
);

	localparam int LogBb = $clog2(BEAT_BYTES);
	localparam logic [tlpc_pkg::LaneW-1:0] LaneAll =
		{tlpc_pkg::LaneW{1'b1}} >> (tlpc_pkg::LaneW - BEAT_BYTES);

	logic [5:0]                    offset;
	logic [6:0]                    run_sh;
	logic [tlpc_pkg::LaneW-1:0]    lane_run;
	logic [tlpc_pkg::LaneW-1:0]    active;
	logic [tlpc_pkg::LaneW-1:0]    mask_ext;
	logic [tlpc_pkg::AddrW-1:0]    low_addr;
	logic                          bad_rsp;

	assign offset   = smp.address[5:0] & 6'(BEAT_BYTES - 1);
	// narrow transfers cover two to the power size lanes
	assign run_sh   = 7'(tlpc_pkg::LaneW) - (7'd1 << smp.size);
	assign lane_run = (smp.size >= tlpc_pkg::SizeW'(LogBb)) ? LaneAll
		: ({tlpc_pkg::LaneW{1'b1}} >> run_sh);
	assign active   = lane_run << offset;
	assign mask_ext = tlpc_pkg::LaneW'(smp.mask);
	assign low_addr = smp.address & ~({tlpc_pkg::AddrW{1'b1}} << smp.size);

	always_comb begin
		bad_rsp = 1'b0;
		case (rec.opc) inside
			tlpc_pkg::OpGet, tlpc_pkg::OpArithmetic, tlpc_pkg::OpLogical: begin
				bad_rsp = (smp.opcode != tlpc_pkg::OpAccessAckData);
			end
			tlpc_pkg::OpPutFull, tlpc_pkg::OpPutPartial: begin
				bad_rsp = (smp.opcode != tlpc_pkg::OpAccessAck);
			end
			tlpc_pkg::OpIntent: begin
				bad_rsp = (smp.opcode != tlpc_pkg::OpHintAck);
			end
			default: begin
				bad_rsp = 1'b0;
			end
		endcase
	end

	always_comb begin
		res = '0;
		if (smp.op == tlpc_pkg::ChanD) begin
			res.size_mismatch  = smp.valid_req && (rec.sz != smp.size);
			res.wrong_response = smp.valid_req && bad_rsp;
			res.burst_unstable = d_unstable;
		end else begin
			res.misaligned        = smp.valid_req && (low_addr != '0);
			res.mask_extra_lane   = smp.valid_req && ((~active & mask_ext) != '0);
			res.mask_missing_lane = smp.valid_req && (smp.opcode != tlpc_pkg::OpPutPartial)
				&& (active != mask_ext);
			res.burst_unstable    = a_unstable;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/tilelink_protocol_checker.sv -----
// ----------------------------------------------------------------------------
// tilelink_protocol_checker
// tilelink bus monitor, one sampled channel word in, one check word out
// ----------------------------------------------------------------------------
// usage
// - sample: one clock of one tilelink channel (a or d) per word; for a bus
//   clock feed the d word first, then the a word
// - result: six flags per sample word, in sample order
// - pipeline: the request table is read at the accepting edge along with the
//   input register, then all checks and state updates happen between it and
//   the result register
// - throughput: one word per cycle while results drain; the sample side keeps
//   taking words while a result waits, up to one word held in the input register
// - stall: a stalled result holds; once the input register is also full,
//   sample_ready drops until result_ready returns
// - reset: burst trackers go idle and every source record reads as intent of
//   size zero; valid bits on the table make this immediate, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module tilelink_protocol_checker #(
	parameter int BEAT_BYTES  = tlpc_pkg::DefBeatBytes,
	parameter int SOURCE_BITS = tlpc_pkg::DefSourceBits
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              sample_valid,
	output logic                   sample_ready,
	input  wire tlpc_pkg::sample_t sample,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output tlpc_pkg::result_t      result
);

	tlpc_pkg::sample_t smp_s1;
	logic              vld_s1;
	tlpc_pkg::result_t res_q;
	logic              res_vld_q;

	logic              accept;
	logic              adv;
	logic              xfer;
	logic              a_step;
	logic              d_step;
	logic              a_unstable;
	logic              d_unstable;
	tlpc_pkg::rec_t    rec;
	tlpc_pkg::rec_wr_t rec_wr;
	tlpc_pkg::result_t res_d;

	assign adv          = vld_s1 && (!res_vld_q || result_ready);
	assign sample_ready = !vld_s1 || adv;
	assign accept       = sample_valid && sample_ready;

	assign xfer   = smp_s1.valid_req && smp_s1.ready_req;
	assign a_step = adv && xfer && (smp_s1.op == tlpc_pkg::ChanA);
	assign d_step = adv && xfer && (smp_s1.op == tlpc_pkg::ChanD);

	assign rec_wr.en          = a_step;
	assign rec_wr.source      = smp_s1.source;
	assign rec_wr.data.opc    = smp_s1.opcode;
	assign rec_wr.data.sz     = smp_s1.size;

	tlpc_record #(
		.SOURCE_BITS(SOURCE_BITS)
	) u_record (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_source(sample.source),
		.wr       (rec_wr),
		.rec      (rec)
	);

	tlpc_burst #(
		.BEAT_BYTES(BEAT_BYTES),
		.CTL_BITS  (tlpc_pkg::ACtlW),
		.CMP_BITS  (tlpc_pkg::ACtlW)
	) u_burst_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (a_step),
		.start_ok(smp_s1.opcode <= tlpc_pkg::OpLogical),
		.size    (smp_s1.size),
		.ctl     ({smp_s1.address, smp_s1.source, smp_s1.size, smp_s1.param,
			smp_s1.opcode}),
		.unstable(a_unstable)
	);

	// d error is left out of the compare until the last beat
	tlpc_burst #(
		.BEAT_BYTES(BEAT_BYTES),
		.CTL_BITS  (tlpc_pkg::DCtlW),
		.CMP_BITS  (tlpc_pkg::DCtlW - 1)
	) u_burst_d (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (d_step),
		.start_ok((smp_s1.opcode == tlpc_pkg::OpAccessAckData)
			|| (smp_s1.opcode == tlpc_pkg::OpGrantData)),
		.size    (smp_s1.size),
		.ctl     ({smp_s1.error, smp_s1.sink, smp_s1.source, smp_s1.size,
			smp_s1.param, smp_s1.opcode}),
		.unstable(d_unstable)
	);

	tlpc_check #(
		.BEAT_BYTES(BEAT_BYTES)
	) u_check (
		.smp       (smp_s1),
		.rec       (rec),
		.a_unstable(a_unstable),
		.d_unstable(d_unstable),
		.res       (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv) begin
				res_vld_q <= 1'b1;
			end else if (result_ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			smp_s1 <= sample;
		end
		if (adv) begin
			res_q <= res_d;
		end
	end

	assign result_valid = res_vld_q;
	assign result       = res_q;

endmodule

`default_nettype wire

// ----- hw/rtl/tlpc_checker.sv -----
// ----------------------------------------------------------------------------
// tlpc_checker
// port-level assertions on the protocol checker, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tlpc_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              sample_valid,
	input wire logic              sample_ready,
	input wire tlpc_pkg::sample_t sample,
	input wire logic              result_valid,
	input wire logic              result_ready,
	input wire tlpc_pkg::result_t result
);

	logic d_flags;
	logic a_flags;
	logic sample_seen;

	assign d_flags     = result.size_mismatch || result.wrong_response;
	assign a_flags     = result.misaligned || result.mask_extra_lane || result.mask_missing_lane;
	assign sample_seen = sample_valid && (sample.op == tlpc_pkg::ChanA || sample.op == tlpc_pkg::ChanD);

	// a word flags either channel's checks, never both
	`ASSERT_NEVER(a_mix_channels, clk, arst_n, result_valid && d_flags && a_flags)

	// an empty or draining result stage never blocks the sample side
	`ASSERT_IMPL(a_ready_empty, clk, arst_n, !result_valid || result_ready, sample_ready)

	// a stalled result holds
	`ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready,
		result_valid && $stable(result))

	// a rising result needs the sample side to have been ready or offered a sample earlier
	`ASSERT_IMPL(a_result_cause, clk, arst_n, $rose(result_valid),
		$past(sample_ready, 1) || $past(sample_seen, 2) || $past(sample_ready, 2))

endmodule

bind tilelink_protocol_checker tlpc_checker u_tlpc_checker (.*);

`default_nettype wire
